// ===== src/rpgb_pkg.sv =====
// ----------------------------------------------------------------------------
// rpgb_pkg
// Shared types and constants of the raw pixel grey and bitmap converter.
// ----------------------------------------------------------------------------
`default_nettype none

package rpgb_pkg;

  // Luma weights, scaled by one thousand.
  localparam int unsigned RedWeight   = 299;
  localparam int unsigned GreenWeight = 587;
  localparam int unsigned BlueWeight  = 114;
  localparam int unsigned LumaScale   = 1000;

  localparam int unsigned PixelWidth = 8;
  localparam int unsigned WidthBits  = 16;
  localparam int unsigned PackBits   = 8;
  localparam int unsigned PackIdxW   = $clog2(PackBits);

  // The weighted sum is at most 255 * 1000.
  localparam int unsigned SumWidth = $clog2((2 ** PixelWidth - 1) * LumaScale + 1);

  // Reciprocal of the scale: floor(x / 1000) == (x * RecipMul) >> RecipShift
  // for every sum that the weights can produce.
  localparam int unsigned RecipShift = 28;
  localparam longint unsigned RecipMul = ((64'd1 << RecipShift) + LumaScale - 1) / LumaScale;
  localparam int unsigned RecipWidth = $clog2(RecipMul + 1);
  localparam int unsigned ProdWidth  = SumWidth + RecipWidth;

  localparam int unsigned CfgIdxWidth = 2;

  typedef enum logic [CfgIdxWidth-1:0] {
    CfgConversionMode = 2'd0,
    CfgImageWidth     = 2'd1,
    CfgGreyMax        = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ChanRed   = 2'd0,
    ChanGreen = 2'd1,
    ChanBlue  = 2'd2
  } chan_e;

  // Request held between the gather stage and the output stage.
  typedef struct packed {
    logic                is_bitmap;
    logic [SumWidth-1:0] sum;
    logic [PackBits-1:0] packed_byte;
  } mid_req_t;

endpackage

`default_nettype wire

// ===== src/raw_pixel_grey_and_bitmap_converter.sv =====
// ----------------------------------------------------------------------------
// raw_pixel_grey_and_bitmap_converter
// Converts raw image body bytes to grey bytes or to packed one-bit bitmaps.
// ----------------------------------------------------------------------------
// Usage:
//   Pixel bytes enter on the in_valid_i/in_ready_o channel, results leave on
//   out_valid_o/out_ready_i. In colour mode every third byte (blue) completes
//   a request that yields one grey byte; in bitmap mode every eighth pixel,
//   or the last pixel of a row whose width is not a multiple of eight,
//   yields one packed byte padded with ones. Other bytes give no result.
//   The configuration channel (cfg_valid_i, cfg_index_i, cfg_data_i) is
//   always ready; the user must write it only while the block is idle, and
//   the block itself does not enforce this. Throughput is one byte per cycle
//   while the receiver does not stall. The register after the channel and
//   packing logic holds the weighted sum or packed byte; the output register
//   follows the reciprocal multiply that divides the sum by the luma scale.
//   When the receiver stalls, the two stages fill and then in_ready_o drops;
//   nothing is lost. Reset empties both stages and clears all channel and
//   packing state; the registers return to colour mode, width 1, max 255.
// ----------------------------------------------------------------------------
`default_nettype none

module raw_pixel_grey_and_bitmap_converter (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  cfg_valid_i,
  output logic                                       cfg_ready_o,
  input  wire logic [rpgb_pkg::CfgIdxWidth-1:0]      cfg_index_i,
  input  wire logic [rpgb_pkg::WidthBits-1:0]        cfg_data_i,
  input  wire logic                                  in_valid_i,
  output logic                                       in_ready_o,
  input  wire logic [rpgb_pkg::PixelWidth-1:0]       pixel_byte_i,
  output logic                                       out_valid_o,
  input  wire logic                                  out_ready_i,
  output logic      [rpgb_pkg::PixelWidth-1:0]       out_byte_o
);

  localparam int unsigned PW = rpgb_pkg::PixelWidth;
  localparam int unsigned WW = rpgb_pkg::WidthBits;
  localparam int unsigned KB = rpgb_pkg::PackBits;
  localparam int unsigned KI = rpgb_pkg::PackIdxW;
  localparam int unsigned SW = rpgb_pkg::SumWidth;

  // Configuration registers.
  logic          mode_q;
  logic [WW-1:0] width_q;
  logic [PW-1:0] grey_max_q;

  // Item state.
  rpgb_pkg::chan_e chan_q, chan_d;
  logic [PW-1:0]   red_q, red_d, green_q, green_d;
  logic [KB-1:0]   acc_q, acc_d;
  logic [WW-1:0]   count_q, count_d;

  // Pipeline.
  logic               mid_valid_q;
  rpgb_pkg::mid_req_t mid_q, mid_d;
  logic               mid_fire;
  logic               out_valid_q;
  logic [PW-1:0]      out_q;
  logic [PW-1:0]      luma;
  logic               in_fire, out_free, mid_free;

  // Bitmap helpers.
  logic [PW-1:0]   threshold;
  logic            pix_bit;
  logic [KB-1:0]   acc_shift;
  logic [WW-1:0]   count_inc;
  logic [KI-1:0]   fill;
  logic [2*KB-1:0] padded;
  logic            byte_full, row_end;

  assign cfg_ready_o = 1'b1;
  assign out_free    = !out_valid_q || out_ready_i;
  assign mid_free    = !mid_valid_q || out_free;
  assign in_ready_o  = mid_free;
  assign in_fire     = in_valid_i && in_ready_o;
  assign mid_fire    = mid_valid_q && out_free;
  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= 1'b0;
      width_q    <= WW'(1);
      grey_max_q <= '1;
    end else if (cfg_valid_i) begin
      case (rpgb_pkg::cfg_idx_e'(cfg_index_i))
        rpgb_pkg::CfgConversionMode: mode_q     <= cfg_data_i[0];
        rpgb_pkg::CfgImageWidth:     width_q    <= cfg_data_i;
        rpgb_pkg::CfgGreyMax:        grey_max_q <= cfg_data_i[PW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    // Threshold is (max + 1) / 2, which fits in the pixel width.
    threshold = PW'(({1'b0, grey_max_q} + (PW+1)'(1)) >> 1);
    pix_bit   = (pixel_byte_i <= threshold);
    acc_shift = {acc_q[KB-2:0], pix_bit};
    count_inc = count_q + WW'(1);
    byte_full = (count_inc[KI-1:0] == '0);
    row_end   = (width_q[KI-1:0] != '0) && (count_inc == width_q);
    // Pad the remaining low bits of the row's last byte with ones.
    fill      = KI'(~count_inc[KI-1:0] + KI'(1));
    padded    = {acc_shift, {KB{1'b1}}} << fill;

    chan_d  = chan_q;
    red_d   = red_q;
    green_d = green_q;
    acc_d   = acc_q;
    count_d = count_q;
    mid_d.is_bitmap   = mode_q;
    mid_d.sum         = '0;
    mid_d.packed_byte = '0;
    if (!mode_q) begin
      case (chan_q)
        rpgb_pkg::ChanRed: begin
          red_d  = pixel_byte_i;
          chan_d = rpgb_pkg::ChanGreen;
        end
        rpgb_pkg::ChanGreen: begin
          green_d = pixel_byte_i;
          chan_d  = rpgb_pkg::ChanBlue;
        end
        default: begin
          chan_d = rpgb_pkg::ChanRed;
        end
      endcase
      mid_d.sum = SW'(SW'(red_q) * SW'(rpgb_pkg::RedWeight)) +
                  SW'(SW'(green_q) * SW'(rpgb_pkg::GreenWeight)) +
                  SW'(SW'(pixel_byte_i) * SW'(rpgb_pkg::BlueWeight));
    end else begin
      acc_d   = acc_shift;
      count_d = count_inc;
      if (byte_full) begin
        mid_d.packed_byte = acc_shift;
        acc_d = '0;
      end
      if (row_end) begin
        mid_d.packed_byte = padded[2*KB-1:KB];
        acc_d   = '0;
        count_d = '0;
      end
    end
  end

  // True when the accepted byte completes a result.
  logic makes_result;
  assign makes_result = mode_q ? (byte_full || row_end)
                               : (chan_q != rpgb_pkg::ChanRed &&
                                  chan_q != rpgb_pkg::ChanGreen);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chan_q      <= rpgb_pkg::ChanRed;
      red_q       <= '0;
      green_q     <= '0;
      acc_q       <= '0;
      count_q     <= '0;
      mid_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        chan_q  <= chan_d;
        red_q   <= red_d;
        green_q <= green_d;
        acc_q   <= acc_d;
        count_q <= count_d;
      end
      if (mid_free) begin
        mid_valid_q <= in_fire && makes_result;
      end
      if (out_free) begin
        out_valid_q <= mid_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && makes_result) begin
      mid_q <= mid_d;
    end
    if (mid_fire) begin
      out_q <= mid_q.is_bitmap ? mid_q.packed_byte : luma;
    end
  end

  rpgb_luma_div u_luma_div (
    .sum_i  (mid_q.sum),
    .luma_o (luma)
  );

endmodule

`default_nettype wire

// ===== src/rpgb_luma_div.sv =====
// ----------------------------------------------------------------------------
// rpgb_luma_div
// Divides the weighted colour sum by the luma scale with a reciprocal multiply.
// ----------------------------------------------------------------------------
`default_nettype none

module rpgb_luma_div (
  input  wire logic [rpgb_pkg::SumWidth-1:0]   sum_i,
  output logic      [rpgb_pkg::PixelWidth-1:0] luma_o
);

  logic [rpgb_pkg::ProdWidth-1:0] prod;

  always_comb begin
    prod = rpgb_pkg::ProdWidth'(sum_i) *
           rpgb_pkg::ProdWidth'(rpgb_pkg::RecipMul);
    luma_o = prod[rpgb_pkg::RecipShift +: rpgb_pkg::PixelWidth];
  end

endmodule

`default_nettype wire
